// ===== rtl/phc_pkg.sv =====
`timescale 1ns / 1ps

package phc_pkg;

    localparam int PATH_ENTRIES_DEF = 16;
    localparam int CFG_DATA_W       = 20;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NOP   = 2'd3
    } req_kind_t;

    typedef enum logic {
        CFG_BASE_GAIN = 1'b0,
        CFG_TIMEOUT   = 1'b1
    } cfg_index_t;

    localparam logic [3:0]  ACT_STOP = 4'd10;

    localparam logic [19:0] BASE_GAIN_RST = 20'd5243;
    localparam logic [15:0] TIMEOUT_RST   = 16'd900;
    localparam logic [19:0] GAIN_MID      = 20'd5243;
    localparam logic [19:0] GAIN_LOW      = 20'd1049;

    // heading thresholds in 1/16 degree
    localparam logic [25:0] ERR_ZERO = 26'd48;
    localparam logic [25:0] ERR_LOW  = 26'd160;
    localparam logic [25:0] ERR_MIN  = 26'd320;
    localparam logic [25:0] ERR_MAX  = 26'd960;
    localparam logic [25:0] ERR_MID  = 26'd1280;
    localparam logic [15:0] RATE_HIGH = 16'd3360;
    localparam logic [15:0] RATE_MID  = 16'd1920;

    localparam logic [15:0] ROT_MAX    = 16'd32767;
    localparam logic [15:0] ROT_MIN    = 16'd6226;
    localparam logic [46:0] PROD_LIMIT = 47'h1000000;

    typedef struct packed {
        logic [15:0]        distance;
        logic signed [7:0]  speed;
        logic signed [13:0] heading;
        logic [3:0]         action;
    } path_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GAIN,
        ST_SCAN,
        ST_ROT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec_load;
        logic exec_start;
        logic exec_tick;
        logic gain_load;
        logic scan_run;
        logic rot_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        req_kind_t req_kind;
        logic      scan_done;
    } dp_status_t;

endpackage

// ===== rtl/phc_if.sv =====
`timescale 1ns / 1ps

interface phc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [3:0]         entry_index;
    logic [15:0]        entry_distance;
    logic signed [7:0]  entry_speed;
    logic signed [13:0] entry_heading;
    logic [3:0]         entry_action;
    logic signed [23:0] distance_reading;
    logic signed [23:0] heading_reading;
    logic signed [15:0] angular_rate;

    modport source (
        output valid, req_type, entry_index, entry_distance, entry_speed,
               entry_heading, entry_action, distance_reading, heading_reading,
               angular_rate,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_distance, entry_speed,
               entry_heading, entry_action, distance_reading, heading_reading,
               angular_rate,
        output ready
    );
endinterface

interface phc_res_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  drive_speed;
    logic signed [15:0] rotate_drive;
    logic [3:0]         action_code;
    logic               finished;
    logic               timed_out;

    modport source (
        output valid, drive_speed, rotate_drive, action_code, finished, timed_out,
        input  ready
    );
    modport sink (
        input  valid, drive_speed, rotate_drive, action_code, finished, timed_out,
        output ready
    );
endinterface

// ===== rtl/phc_ctrl.sv =====
`timescale 1ns / 1ps

module phc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  phc_pkg::dp_status_t   status,
    output phc_pkg::dp_cmd_t      cmd
);

    phc_pkg::state_t state_reg;
    phc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            phc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = phc_pkg::ST_EXEC;
            end
            phc_pkg::ST_EXEC:
            begin
                if (status.req_kind == phc_pkg::REQ_TICK)
                    state_next = phc_pkg::ST_GAIN;
                else
                    state_next = phc_pkg::ST_EMIT;
            end
            phc_pkg::ST_GAIN:
                state_next = phc_pkg::ST_SCAN;
            phc_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = phc_pkg::ST_ROT;
            end
            phc_pkg::ST_ROT:
                state_next = phc_pkg::ST_EMIT;
            phc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = phc_pkg::ST_IDLE;
            end
            default:
                state_next = phc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            phc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            phc_pkg::ST_EXEC:
            begin
                case (status.req_kind)
                    phc_pkg::REQ_LOAD:  cmd.exec_load  = 1'b1;
                    phc_pkg::REQ_START: cmd.exec_start = 1'b1;
                    phc_pkg::REQ_TICK:  cmd.exec_tick  = 1'b1;
                    default:            cmd            = '0;
                endcase
            end
            phc_pkg::ST_GAIN:
                cmd.gain_load = 1'b1;
            phc_pkg::ST_SCAN:
                cmd.scan_run = 1'b1;
            phc_pkg::ST_ROT:
                cmd.rot_load = 1'b1;
            phc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/phc_datapath.sv =====
`timescale 1ns / 1ps

module phc_datapath #(
    parameter int PATH_ENTRIES = phc_pkg::PATH_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  phc_pkg::dp_cmd_t                cmd,
    output phc_pkg::dp_status_t             status,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [phc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]                      req_type,
    input  logic [3:0]                      entry_index,
    input  logic [15:0]                     entry_distance,
    input  logic signed [7:0]               entry_speed,
    input  logic signed [13:0]              entry_heading,
    input  logic [3:0]                      entry_action,
    input  logic signed [23:0]              distance_reading,
    input  logic signed [23:0]              heading_reading,
    input  logic signed [15:0]              angular_rate,
    output logic signed [7:0]               drive_speed,
    output logic signed [15:0]              rotate_drive,
    output logic [3:0]                      action_code,
    output logic                            finished,
    output logic                            timed_out
);

    localparam int IW = (PATH_ENTRIES > 1) ? $clog2(PATH_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_ADDR = IW'(PATH_ENTRIES - 1);

    // captured request
    phc_pkg::req_kind_t   req_reg;
    logic [3:0]           idx_reg;
    phc_pkg::path_entry_t ent_reg;
    logic signed [23:0]   dist_rd_reg;
    logic signed [23:0]   head_rd_reg;
    logic [15:0]          rate_reg;

    // run state
    logic signed [23:0]   initial_heading_reg;
    logic signed [24:0]   target_heading_reg;
    logic signed [7:0]    target_speed_reg;
    logic [15:0]          dist_trav_reg;
    logic signed [23:0]   last_reading_reg;
    logic [1:0]           gain_phase_reg;
    logic                 stop_reg;
    logic [15:0]          tick_reg;
    logic [19:0]          base_gain_reg;
    logic [15:0]          timeout_reg;

    // tick work registers
    logic signed [25:0]   e_reg;
    logic [25:0]          ae_reg;
    logic [19:0]          gain_reg;
    logic signed [46:0]   p_reg;
    logic signed [15:0]   rot_reg;
    logic [3:0]           action_reg;

    // table and scan
    phc_pkg::path_entry_t mem [PATH_ENTRIES];
    phc_pkg::path_entry_t rd_data_reg;
    logic [IW-1:0]        scan_addr_reg;
    logic                 data_ok_reg;
    logic                 data_last_reg;

    // output register
    logic signed [7:0]    drive_speed_reg;
    logic signed [15:0]   rotate_drive_reg;
    logic [3:0]           action_code_reg;
    logic                 finished_reg;
    logic                 timed_out_reg;

    logic [15:0]          rate_abs;
    logic [24:0]          diff_w;
    logic [24:0]          diff_abs;
    logic [25:0]          dist_sum;
    logic [15:0]          dist_next;
    logic signed [25:0]   err_w;
    logic [25:0]          ae_w;
    logic                 keep_base;
    logic                 use_mid;
    logic                 use_low;
    logic [19:0]          gain_next;
    logic [1:0]           gain_phase_next;
    logic                 idx_ok;
    logic [IW-1:0]        waddr;
    logic                 hit;
    logic signed [24:0]   hit_heading;
    logic [46:0]          abs_p;
    logic                 prod_big;
    logic [25:0]          rnd;
    logic [16:0]          rnd_sh;
    logic [15:0]          mag_a;
    logic [15:0]          mag_b;
    logic                 p_pos;
    logic signed [15:0]   rot_next;

    assign rate_abs = angular_rate[15] ? (~angular_rate + 16'd1) : angular_rate;

    assign diff_w   = {dist_rd_reg[23], dist_rd_reg} - {last_reading_reg[23], last_reading_reg};
    assign diff_abs = diff_w[24] ? (~diff_w + 25'd1) : diff_w;
    assign dist_sum = {10'd0, dist_trav_reg} + {1'b0, diff_abs};
    assign dist_next = (|dist_sum[25:16]) ? 16'hFFFF : dist_sum[15:0];

    assign err_w = {target_heading_reg[24], target_heading_reg}
                 - {{2{head_rd_reg[23]}}, head_rd_reg};

    // gain schedule
    assign ae_w      = e_reg[25] ? (~e_reg + 26'd1) : e_reg;
    assign keep_base = (ae_w < phc_pkg::ERR_MAX) && (ae_w > phc_pkg::ERR_MIN)
                    && (rate_reg > phc_pkg::RATE_HIGH);
    assign use_mid   = ((ae_w < phc_pkg::ERR_MID) && (rate_reg > phc_pkg::RATE_MID))
                    || (gain_phase_reg == 2'd1);
    assign use_low   = ae_w < phc_pkg::ERR_LOW;

    always_comb
    begin
        gain_next       = base_gain_reg;
        gain_phase_next = gain_phase_reg;
        if (!keep_base)
        begin
            if (use_low)
            begin
                gain_next       = phc_pkg::GAIN_LOW;
                gain_phase_next = 2'd2;
            end
            else if (use_mid)
            begin
                gain_next       = phc_pkg::GAIN_MID;
                gain_phase_next = 2'd1;
            end
        end
    end

    assign idx_ok = {28'd0, idx_reg} < 32'(PATH_ENTRIES);
    assign waddr  = IW'(idx_reg);

    assign hit = data_ok_reg && (rd_data_reg.distance >= dist_trav_reg);
    assign hit_heading = {{11{rd_data_reg.heading[13]}}, rd_data_reg.heading}
                       + {initial_heading_reg[23], initial_heading_reg};

    assign status.req_kind  = req_reg;
    assign status.scan_done = data_ok_reg && (hit || data_last_reg);

    // rotate command from the product
    assign abs_p    = p_reg[46] ? (~p_reg + 47'd1) : p_reg;
    assign prod_big = abs_p > phc_pkg::PROD_LIMIT;
    assign rnd      = {1'b0, abs_p[24:0]} + 26'd256;
    assign rnd_sh   = rnd[25:9];
    assign mag_a    = (prod_big || (rnd_sh > {1'b0, phc_pkg::ROT_MAX}))
                    ? phc_pkg::ROT_MAX : rnd_sh[15:0];
    assign mag_b    = (mag_a < phc_pkg::ROT_MIN) ? phc_pkg::ROT_MIN : mag_a;
    assign p_pos    = !p_reg[46] && (|p_reg);
    assign rot_next = (ae_reg < phc_pkg::ERR_ZERO) ? 16'sd0
                    : (p_pos ? $signed(mag_b) : $signed(~mag_b + 16'd1));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_gain_reg <= phc_pkg::BASE_GAIN_RST;
            timeout_reg   <= phc_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (phc_pkg::cfg_index_t'(cfg_index))
                phc_pkg::CFG_BASE_GAIN: base_gain_reg <= cfg_data;
                phc_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                default:                timeout_reg   <= timeout_reg;
            endcase
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_heading_reg <= '0;
            target_heading_reg  <= '0;
            target_speed_reg    <= '0;
            dist_trav_reg       <= '0;
            last_reading_reg    <= '0;
            gain_phase_reg      <= '0;
            stop_reg            <= 1'b0;
            tick_reg            <= '0;
        end
        else
        begin
            if (cmd.exec_start)
            begin
                initial_heading_reg <= head_rd_reg;
                target_heading_reg  <= {head_rd_reg[23], head_rd_reg};
                dist_trav_reg       <= '0;
                last_reading_reg    <= '0;
                gain_phase_reg      <= '0;
                stop_reg            <= 1'b0;
                tick_reg            <= '0;
            end
            if (cmd.exec_tick)
            begin
                last_reading_reg <= dist_rd_reg;
                dist_trav_reg    <= dist_next;
                if (tick_reg != 16'hFFFF)
                    tick_reg <= tick_reg + 16'd1;
            end
            if (cmd.gain_load)
                gain_phase_reg <= gain_phase_next;
            if (cmd.scan_run && hit)
            begin
                target_speed_reg   <= rd_data_reg.speed;
                target_heading_reg <= hit_heading;
                if (rd_data_reg.action == phc_pkg::ACT_STOP)
                    stop_reg <= 1'b1;
            end
        end
    end

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            data_ok_reg   <= 1'b0;
            data_last_reg <= 1'b0;
        end
        else if (cmd.gain_load)
        begin
            scan_addr_reg <= '0;
            data_ok_reg   <= 1'b0;
            data_last_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            data_ok_reg   <= 1'b1;
            data_last_reg <= scan_addr_reg == LAST_ADDR;
            // hold at the last entry
            if (scan_addr_reg != LAST_ADDR)
                scan_addr_reg <= scan_addr_reg + 1'b1;
        end
    end

    // path table
    always_ff @(posedge clk)
    begin
        if (cmd.exec_load && idx_ok)
            mem[waddr] <= ent_reg;
        if (cmd.scan_run)
            rd_data_reg <= mem[scan_addr_reg];
    end

    // request capture and tick work registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg             <= phc_pkg::req_kind_t'(req_type);
            idx_reg             <= entry_index;
            ent_reg.distance    <= entry_distance;
            ent_reg.speed       <= entry_speed;
            ent_reg.heading     <= entry_heading;
            ent_reg.action      <= entry_action;
            dist_rd_reg         <= distance_reading;
            head_rd_reg         <= heading_reading;
            rate_reg            <= rate_abs;
        end
        if (cmd.exec_tick)
        begin
            e_reg      <= err_w;
            action_reg <= '0;
        end
        if (cmd.gain_load)
        begin
            gain_reg <= gain_next;
            ae_reg   <= ae_w;
        end
        if (cmd.scan_run)
        begin
            p_reg <= e_reg * $signed({1'b0, gain_reg});
            if (hit)
                action_reg <= rd_data_reg.action;
        end
        if (cmd.rot_load)
            rot_reg <= rot_next;
        if (cmd.out_load)
        begin
            drive_speed_reg  <= target_speed_reg;
            rotate_drive_reg <= (req_reg == phc_pkg::REQ_TICK) ? rot_reg : 16'sd0;
            action_code_reg  <= (req_reg == phc_pkg::REQ_TICK) ? action_reg : 4'd0;
            finished_reg     <= stop_reg;
            timed_out_reg    <= tick_reg >= timeout_reg;
        end
    end

    assign drive_speed  = drive_speed_reg;
    assign rotate_drive = rotate_drive_reg;
    assign action_code  = action_code_reg;
    assign finished     = finished_reg;
    assign timed_out    = timed_out_reg;

endmodule

// ===== rtl/path_heading_controller.sv =====
// Channel   Direction  Transaction
// request   in         load entry, start run, control tick or no-op (req_type selects)
// result    out        drive_speed, rotate_drive, action_code, finished, timed_out
// cfg       in         write-only: cfg_we, cfg_index (0 base_gain, 1 timeout_ticks)
//
// One transaction at a time; a result per request.
// Load, start: the request passes the EXEC and EMIT states into the result register.
// Tick: EXEC, GAIN, a scan up to the first matching slot or the last slot, ROT, EMIT;
// the table scan reads one entry a cycle from the single-port table.
// A new request is taken while the result register still waits; a stalled
// result holds the next one back. Reset is asynchronous, active low; no table clear.
`timescale 1ns / 1ps

module path_heading_controller #(
    parameter int PATH_ENTRIES = phc_pkg::PATH_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    phc_req_if.sink                         request,
    phc_res_if.source                       result,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [phc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    phc_pkg::dp_cmd_t    cmd;
    phc_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;

    phc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    phc_datapath #(
        .PATH_ENTRIES (PATH_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (request.req_type),
        .entry_index      (request.entry_index),
        .entry_distance   (request.entry_distance),
        .entry_speed      (request.entry_speed),
        .entry_heading    (request.entry_heading),
        .entry_action     (request.entry_action),
        .distance_reading (request.distance_reading),
        .heading_reading  (request.heading_reading),
        .angular_rate     (request.angular_rate),
        .drive_speed      (result.drive_speed),
        .rotate_drive     (result.rotate_drive),
        .action_code      (result.action_code),
        .finished         (result.finished),
        .timed_out        (result.timed_out)
    );

    assign request.ready = in_ready;
    assign result.valid  = out_valid;

    // busy right after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request accepted while busy");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec_load, cmd.exec_start, cmd.exec_tick,
                  cmd.gain_load, cmd.scan_run, cmd.rot_load, cmd.out_load}))
        else $error("overlapping datapath commands");

    // a loaded result shows up on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result.valid)
        else $error("result loaded but not valid");

    // capture only when the request side handshakes
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (request.valid && request.ready))
        else $error("capture without transaction");

endmodule
